// ===== hw/rtl/ste_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sierpinski tetrahedron distance package
// Shared widths, types, vertex constants and small helper functions.
// ----------------------------------------------------------------------------
package ste_pkg;

   localparam int ITERATIONS = 15;
   localparam int FRAC_BITS  = 16;
   localparam int IN_W       = 24;
   localparam int OUT_W      = 24;
   localparam int OFF_W      = 16;
   localparam int COORD_W    = 48;
   localparam int HALF_W     = COORD_W / 2;
   localparam int NEXT_W     = COORD_W + 2;
   localparam int SCORE_W    = COORD_W + FRAC_BITS + 8;
   localparam int SQ_W       = 2 * COORD_W + 2;
   localparam int ROOT_W     = OUT_W;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = 2 * ROOT_W + 1;
   localparam int SHIFT      = 2 * ITERATIONS;

   localparam logic [OFF_W-1:0] OFFSET_RESET = OFF_W'(131);

   localparam longint FX_ONE  = longint'(1) << FRAC_BITS;
   localparam longint FX_C    = ((longint'(14) << FRAC_BITS) + 5) / 10;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic signed [NEXT_W-1:0]  next_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   // Vertex codes, in tie-break order.
   localparam logic [1:0] VTX_TOP   = 2'd0;
   localparam logic [1:0] VTX_LEFT  = 2'd1;
   localparam logic [1:0] VTX_RIGHT = 2'd2;
   localparam logic [1:0] VTX_FRONT = 2'd3;

   // The squared distance to each vertex differs from |p|^2 by a term that is
   // linear in p, so nearness is decided by |a|^2 - 2 p.a alone.
   localparam score_type K_TOP   = SCORE_W'(4 * FX_ONE * FX_ONE);
   localparam score_type K_SIDE  = SCORE_W'(FX_C * FX_C + FX_ONE * FX_ONE);
   localparam score_type K_FRONT = SCORE_W'(FX_C * FX_C);
   localparam score_type C_TWO   = SCORE_W'(2 * FX_C);

   function automatic coord_type vertex_x(input logic [1:0] idx);
      coord_type v;
      unique case (idx)
         VTX_LEFT:  v = -COORD_W'(FX_C);
         VTX_RIGHT: v = COORD_W'(FX_C);
         default:   v = '0;
      endcase
      return v;
   endfunction

   function automatic coord_type vertex_y(input logic [1:0] idx);
      coord_type v;
      unique case (idx)
         VTX_TOP: v = COORD_W'(2 * FX_ONE);
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic coord_type vertex_z(input logic [1:0] idx);
      coord_type v;
      unique case (idx)
         VTX_LEFT, VTX_RIGHT: v = -COORD_W'(FX_ONE);
         VTX_FRONT:           v = COORD_W'(FX_C);
         default:             v = '0;
      endcase
      return v;
   endfunction

   function automatic coord_type sat_coord(input next_type v);
      coord_type r;
      if ((v[NEXT_W-1:COORD_W-1] == '0) || (v[NEXT_W-1:COORD_W-1] == '1)) begin
         r = v[COORD_W-1:0];
      end else if (v[NEXT_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ste_fold_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Folding step
// One iteration in two stages: vertex scores, then nearest pick and 2p - a.
// ----------------------------------------------------------------------------
module ste_fold_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire ste_pkg::point_type in_point,
   output logic                   out_valid,
   output ste_pkg::point_type     out_point
);
   import ste_pkg::*;

   score_type px_w, py_w, pz_w, cx, cz;
   score_type s_in [4];

   logic      a_valid_ff;
   point_type a_point_ff;
   score_type a_score_ff [4];

   logic      b_valid_ff;
   point_type b_point_ff;
   point_type b_point_in;
   logic [1:0] best;
   score_type  best_s;

   always_comb begin
      px_w = SCORE_W'(in_point.x);
      py_w = SCORE_W'(in_point.y);
      pz_w = SCORE_W'(in_point.z);
      cx   = px_w * C_TWO;
      cz   = pz_w * C_TWO;
      s_in[0] = K_TOP - (py_w <<< (FRAC_BITS + 2));
      s_in[1] = K_SIDE + cx + (pz_w <<< (FRAC_BITS + 1));
      s_in[2] = K_SIDE - cx + (pz_w <<< (FRAC_BITS + 1));
      s_in[3] = K_FRONT - cz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_point_ff <= in_point;
         for (int i = 0; i < 4; i++) begin
            a_score_ff[i] <= s_in[i];
         end
      end
   end

   // Strict less-than keeps the earlier vertex on a tie.
   always_comb begin
      best   = VTX_TOP;
      best_s = a_score_ff[0];
      for (int v = 1; v < 4; v++) begin
         if (a_score_ff[v] < best_s) begin
            best   = 2'(v);
            best_s = a_score_ff[v];
         end
      end
      b_point_in.x = sat_coord((NEXT_W'(a_point_ff.x) <<< 1) - NEXT_W'(vertex_x(best)));
      b_point_in.y = sat_coord((NEXT_W'(a_point_ff.y) <<< 1) - NEXT_W'(vertex_y(best)));
      b_point_in.z = sat_coord((NEXT_W'(a_point_ff.z) <<< 1) - NEXT_W'(vertex_z(best)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_point_ff <= b_point_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_point = b_point_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ste_square_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Squared length
// Magnitudes, split half-width products, per-axis squares, then the sum
// scaled down by the iteration shift and flagged when beyond the root unit's range.
// ----------------------------------------------------------------------------
module ste_square_sum (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire ste_pkg::point_type           in_point,
   output logic                              out_valid,
   output logic                              out_sat,
   output logic [ste_pkg::RAD_W-1:0]         out_rad
);
   import ste_pkg::*;

   coord_type            comp [3];
   logic [COORD_W-1:0]   mag_in [3];

   logic                 m_valid_ff;
   logic [COORD_W-1:0]   mag_ff [3];

   logic                 p_valid_ff;
   logic [COORD_W-1:0]   hh_ff [3];
   logic [COORD_W-1:0]   hl_ff [3];
   logic [COORD_W-1:0]   ll_ff [3];

   logic                 q_valid_ff;
   logic [2*COORD_W-1:0] sq_ff [3];

   logic                 s_valid_ff;
   logic                 sat_ff;
   logic [RAD_W-1:0]     rad_ff;
   logic [SQ_W-1:0]      total;

   always_comb begin
      comp[0] = in_point.x;
      comp[1] = in_point.y;
      comp[2] = in_point.z;
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = comp[i][COORD_W-1] ? (~comp[i] + 1'b1) : comp[i];
      end
   end

   always_comb begin
      total = '0;
      for (int i = 0; i < 3; i++) begin
         total = total + SQ_W'(sq_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= in_valid;
         p_valid_ff <= m_valid_ff;
         q_valid_ff <= p_valid_ff;
         s_valid_ff <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= mag_in[i];
            hh_ff[i]  <= mag_ff[i][COORD_W-1:HALF_W] * mag_ff[i][COORD_W-1:HALF_W];
            hl_ff[i]  <= mag_ff[i][COORD_W-1:HALF_W] * mag_ff[i][HALF_W-1:0];
            ll_ff[i]  <= mag_ff[i][HALF_W-1:0] * mag_ff[i][HALF_W-1:0];
            sq_ff[i]  <= ((2*COORD_W)'(hh_ff[i]) << COORD_W)
                       + ((2*COORD_W)'(hl_ff[i]) << (HALF_W + 1))
                       + (2*COORD_W)'(ll_ff[i]);
         end
         // Beyond the radicand range the result saturates anyway.
         sat_ff <= |total[SQ_W-1:SHIFT+RAD_W];
         rad_ff <= total[SHIFT+RAD_W-1:SHIFT];
      end
   end

   assign out_valid = s_valid_ff;
   assign out_sat   = sat_ff;
   assign out_rad   = rad_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ste_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// ----------------------------------------------------------------------------
module ste_isqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic                         in_sat,
   input  wire logic [ste_pkg::RAD_W-1:0]    in_rad,
   output logic                              out_valid,
   output logic                              out_sat,
   output logic [ste_pkg::ROOT_W-1:0]        out_root
);
   import ste_pkg::*;

   logic              valid_w [ROOT_W+1];
   logic              sat_w   [ROOT_W+1];
   logic [REM_W-1:0]  rem_w   [ROOT_W+1];
   logic [ROOT_W-1:0] root_w  [ROOT_W+1];

   assign valid_w[0] = in_valid;
   assign sat_w[0]   = in_sat;
   assign rem_w[0]   = REM_W'(in_rad);
   assign root_w[0]  = '0;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      localparam int BIT = ROOT_W - 1 - k;

      logic              valid_ff;
      logic              sat_ff;
      logic [REM_W-1:0]  rem_ff;
      logic [ROOT_W-1:0] root_ff;
      logic [REM_W-1:0]  trial;

      assign trial = (REM_W'(root_w[k]) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sat_ff <= sat_w[k];
            if (rem_w[k] >= trial) begin
               rem_ff  <= rem_w[k] - trial;
               root_ff <= root_w[k] | (ROOT_W'(1) << BIT);
            end else begin
               rem_ff  <= rem_w[k];
               root_ff <= root_w[k];
            end
         end
      end

      assign valid_w[k+1] = valid_ff;
      assign sat_w[k+1]   = sat_ff;
      assign rem_w[k+1]   = rem_ff;
      assign root_w[k+1]  = root_ff;
   end

   assign out_valid = valid_w[ROOT_W];
   assign out_sat   = sat_w[ROOT_W];
   assign out_root  = root_w[ROOT_W];

endmodule

`default_nettype wire

// ===== hw/rtl/sierpinski_tetrahedron_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sierpinski tetrahedron distance estimator
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits on a stalled output register.
// Reset clears all valid bits and loads shell_offset with 131.
// ----------------------------------------------------------------------------
module sierpinski_tetrahedron_distance (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [ste_pkg::IN_W-1:0] req_point_x,
   input  wire logic signed [ste_pkg::IN_W-1:0] req_point_y,
   input  wire logic signed [ste_pkg::IN_W-1:0] req_point_z,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [ste_pkg::OUT_W-1:0]    rsp_distance,
   input  wire logic                           csr_wr_en,
   input  wire logic [ste_pkg::OFF_W-1:0]      csr_wr_data
);
   import ste_pkg::*;

   localparam int DIFF_W = ROOT_W + 2;

   logic                     en;
   logic [OFF_W-1:0]         offset_ff;
   logic                     in_valid_ff;
   point_type                in_point_ff;

   logic                     fold_valid [ITERATIONS+1];
   point_type                fold_point [ITERATIONS+1];

   logic                     sq_valid, sq_sat;
   logic [RAD_W-1:0]         sq_rad;
   logic                     rt_valid, rt_sat;
   logic [ROOT_W-1:0]        rt_root;

   logic signed [DIFF_W-1:0] diff;
   logic signed [OUT_W-1:0]  dist_in;
   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  rsp_distance_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_point_ff.x <= COORD_W'(req_point_x);
         in_point_ff.y <= COORD_W'(req_point_y);
         in_point_ff.z <= COORD_W'(req_point_z);
      end
   end

   assign fold_valid[0] = in_valid_ff;
   assign fold_point[0] = in_point_ff;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_fold
      ste_fold_stage u_fold (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (fold_valid[i]),
         .in_point  (fold_point[i]),
         .out_valid (fold_valid[i+1]),
         .out_point (fold_point[i+1])
      );
   end

   ste_square_sum u_square (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fold_valid[ITERATIONS]),
      .in_point  (fold_point[ITERATIONS]),
      .out_valid (sq_valid),
      .out_sat   (sq_sat),
      .out_rad   (sq_rad)
   );

   ste_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_sat    (sq_sat),
      .in_rad    (sq_rad),
      .out_valid (rt_valid),
      .out_sat   (rt_sat),
      .out_root  (rt_root)
   );

   // The root is never negative, so only the upper clamp can apply.
   always_comb begin
      diff = $signed({2'b00, rt_root}) - $signed({{(DIFF_W-OFF_W){1'b0}}, offset_ff});
      if (rt_sat || (diff > DIFF_W'((longint'(1) << (OUT_W - 1)) - 1))) begin
         dist_in = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
         dist_in = diff[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_distance_ff <= dist_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ste_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports for handshake and range slips.
// ----------------------------------------------------------------------------
module ste_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic signed [ste_pkg::OUT_W-1:0] rsp_distance
);
   import ste_pkg::*;

   // A held result keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance))
      else $error("held result changed");

   // The pipeline freezes whenever the output is blocked.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("item taken while output blocked");

   // Nothing comes out in the cycle after reset.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // A length minus a 16-bit offset cannot fall below minus the offset range.
   a_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance >= -$signed(OUT_W'((longint'(1) << OFF_W) - 1))))
      else $error("distance below offset floor");

endmodule

bind sierpinski_tetrahedron_distance ste_checker u_ste_checker (.*);

`default_nettype wire

// ===== bench/tb_sierpinski_tetrahedron_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sierpinski tetrahedron distance estimator testbench
// Drives query points through the estimator with bursty input and a stalling
// output, predicts every distance with an exact wide-integer model of the
// folding steps, and compares results in order. The shell offset is changed
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_sierpinski_tetrahedron_distance;
   import ste_pkg::*;

   localparam int LATENCY = 2 * ITERATIONS + ROOT_W + 6;

   class distance_scoreboard;
      logic [OFF_W-1:0]          offset;
      logic signed [OUT_W-1:0]   expected_q[$];

      function new();
         offset = OFFSET_RESET;
      endfunction

      function logic [127:0] square(longint d);
         logic [127:0] m;
         m = (d < 0) ? 128'(-d) : 128'(d);
         return m * m;
      endfunction

      function logic signed [OUT_W-1:0] predict(longint x, longint y, longint z);
         longint vx[4], vy[4], vz[4];
         longint px, py, pz, c, one, est;
         logic [127:0] best_sq, sq, cand;
         logic [63:0] root, trial;
         int best;
         one = longint'(1) << FRAC_BITS;
         c = ((longint'(14) << FRAC_BITS) + 5) / 10;
         vx = '{0, -c, c, 0};
         vy = '{2 * one, 0, 0, 0};
         vz = '{0, -one, -one, c};
         px = x; py = y; pz = z;
         for (int it = 0; it < ITERATIONS; it++) begin
            best = 0;
            best_sq = square(px - vx[0]) + square(py - vy[0]) + square(pz - vz[0]);
            for (int v = 1; v < 4; v++) begin
               sq = square(px - vx[v]) + square(py - vy[v]) + square(pz - vz[v]);
               if (sq < best_sq) begin
                  best_sq = sq;
                  best = v;
               end
            end
            px = clamp_coord(2 * px - vx[best]);
            py = clamp_coord(2 * py - vy[best]);
            pz = clamp_coord(2 * pz - vz[best]);
         end
         sq = square(px) + square(py) + square(pz);
         root = '0;
         for (int b = 51; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            cand = 128'(trial) * 128'(trial);
            if (!(sq < cand)) root = trial;
         end
         est = longint'(root >> ITERATIONS) - longint'(offset);
         if (est > 8388607) est = 8388607;
         if (est < -8388608) est = -8388608;
         return OUT_W'(est);
      endfunction

      function longint clamp_coord(longint n);
         longint hi, lo;
         hi = (longint'(1) << 47) - 1;
         lo = -(longint'(1) << 47);
         if (n > hi) return hi;
         if (n < lo) return lo;
         return n;
      endfunction

      function void note_point(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                               logic signed [IN_W-1:0] z);
         expected_q.push_back(predict(longint'(x), longint'(y), longint'(z)));
      endfunction

      // Returns 0 when nothing was waiting for this result.
      function bit check_distance(logic signed [OUT_W-1:0] got,
                                  output logic signed [OUT_W-1:0] want, output bit ok);
         if (expected_q.size() == 0) begin
            want = '0;
            ok = 1'b0;
            return 1'b0;
         end
         want = expected_q.pop_front();
         ok = (got === want);
         return 1'b1;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [IN_W-1:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_distance;
   logic csr_wr_en = 1'b0;
   logic [OFF_W-1:0] csr_wr_data = '0;

   distance_scoreboard sb = new();
   int errors = 0;
   int items_in = 0;
   int results_out = 0;
   int burst_left = 0;
   int stall_mode = 0;

   always #6 clock = ~clock;

   sierpinski_tetrahedron_distance dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_distance(rsp_distance),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   task automatic report(string msg);
      errors++;
      if (errors <= 30) $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_point(req_point_x, req_point_y, req_point_z);
         items_in++;
      end
   end

   always @(posedge clock) begin
      logic signed [OUT_W-1:0] want;
      bit ok;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_out++;
         if (!sb.check_distance(rsp_distance, want, ok))
            report($sformatf("unexpected distance %0d", rsp_distance));
         else if (!ok)
            report($sformatf("distance got %0d want %0d", rsp_distance, want));
      end
   end

   // The receiver now and then switches to a randomly chosen stall habit.
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= (($time / 12) % 7) < 3;
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   task automatic send_point(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                             logic signed [IN_W-1:0] z);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end else begin
         @(negedge clock);
      end
      burst_left--;
      req_valid = 1'b1;
      req_point_x = x;
      req_point_y = y;
      req_point_z = z;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_offset(logic [OFF_W-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.offset = value;
   endtask

   function automatic logic signed [IN_W-1:0] rand_coord();
      // Mostly points near the fractal, where the folding choice matters.
      if ($urandom_range(0, 9) < 7)
         return IN_W'(int'($urandom_range(0, 393216)) - 196608);
      return IN_W'($urandom);
   endfunction

   task automatic random_points(int count);
      for (int i = 0; i < count; i++) send_point(rand_coord(), rand_coord(), rand_coord());
   endtask

   initial begin
      logic signed [IN_W-1:0] c;
      c = IN_W'(91750);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Extremes, the origin, the vertices themselves and tie points.
      send_point(0, 0, 0);
      send_point(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
      send_point(-24'sh800000, -24'sh800000, -24'sh800000);
      send_point(24'sh7fffff, -24'sh800000, 24'sh7fffff);
      send_point(-24'sh800000, 24'sh7fffff, -24'sh800000);
      send_point(0, 131072, 0);
      send_point(-c, 0, -65536);
      send_point(c, 0, -65536);
      send_point(0, 0, c);
      send_point(0, 65536, 0);
      send_point(0, 0, -65536);
      send_point(0, 65536, 65536);
      send_point(1, -1, 1);
      send_point(-1, -1, -1);
      send_point(24'shffffff, 24'sh000001, 24'sh555555);
      send_point(24'shaaaaaa, 24'sh555555, 24'shaaaaaa);
      wait_drained();

      write_offset(16'd0);
      random_points(250);
      wait_drained();
      write_offset(16'hffff);
      send_point(0, 0, 0);
      send_point(-24'sh800000, 24'sh7fffff, 24'sh7fffff);
      random_points(250);
      wait_drained();
      write_offset(16'h0001);
      random_points(250);
      wait_drained();
      write_offset(OFF_W'($urandom));
      random_points(250);
      wait_drained();
      write_offset(OFFSET_RESET);
      random_points(230);
      wait_drained();

      $display("Covered %0d points and %0d distances over five shell offsets,",
               items_in, results_out);
      $display("with bursty input, varied output stalls and full pipeline drains.");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
